### sv/ps2md_pkg.sv
// Shared types, widths and helper functions for the PS/2 mouse packet decoder.
// No dependencies; used by ps2_mouse_packet_decoder and its checker.
`default_nettype none

package ps2md_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIM_W      = COORD_BITS + 1;
    localparam int SUM_W      = COORD_BITS + 2;
    localparam int SCREEN_W   = 13;
    localparam int DELTA_W    = 10;
    localparam int WHEEL_W    = 5;
    localparam int BTN_W      = 3;
    localparam int OUT_BITS   = 2 * COORD_BITS + 2 * DELTA_W + WHEEL_W + BTN_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [7:0] SYNC_MASK   = 8'h08;
    localparam logic [7:0] BUTTON_MASK = 8'h07;

    typedef enum logic [1:0] {
        OP_DATA     = 2'd0,
        OP_RECENTER = 2'd1,
        OP_RESYNC   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_FOUR_BYTE   = 2'd1,
        CFG_SCREEN_W    = 2'd2,
        CFG_SCREEN_H    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [BTN_W-1:0]      button_bits;
        logic [WHEEL_W-1:0]    wheel_step;
        logic [DELTA_W-1:0]    delta_y;
        logic [DELTA_W-1:0]    delta_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] pos_x;
    } event_t;

    function automatic logic [DIM_W-1:0] limit_dim(input logic [SCREEN_W-1:0] d);
        logic [31:0] cap;
        logic [31:0] wide;
        cap  = 32'd1 << COORD_BITS;
        wide = 32'(d);
        limit_dim = (wide > cap) ? DIM_W'(cap) : DIM_W'(wide);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic signed [SUM_W-1:0] p,
        input logic [DIM_W-1:0]        dim
    );
        logic [DIM_W-1:0] mag;
        mag = p[DIM_W-1:0];
        if (p < 0) begin
            clamp_axis = '0;
        end else if (mag >= dim) begin
            clamp_axis = COORD_BITS'(dim - DIM_W'(1));
        end else begin
            clamp_axis = mag[COORD_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### sv/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder: packet assembly, cursor update
// and a two-entry output buffer. Depends on ps2md_pkg.
//
//   channel  | direction | handshake                    | payload
//   s_       | in        | s_tvalid / s_tready          | tuser: opcode, tdata: data_byte
//   m_       | out       | m_tvalid / m_tready          | tdata: event fields
//   cfg_     | in        | cfg_we (no wait)             | cfg_index, cfg_wdata
//
// One item per cycle while s_tready is high; results land in the output or skid register.
// All decoding, the cursor add and the clamp sit between the input port and result registers.
// aresetn is synchronous: clears config to defaults, cursor, counters and valids.
// s_tready drops only while both output entries hold untaken results.
`default_nettype none

module ps2_mouse_packet_decoder (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]                       s_tuser,   // [1:0] opcode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [11:0] pos_x, [23:12] pos_y, [33:24] delta_x, [43:34] delta_y,
    // [48:44] wheel_step, [51:49] button_bits, rest zero
    output logic [ps2md_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [ps2md_pkg::SCREEN_W-1:0]   cfg_wdata
);

    localparam int CB = ps2md_pkg::COORD_BITS;

    logic                             enable_reg;
    logic                             four_byte_reg;
    logic [ps2md_pkg::SCREEN_W-1:0]   screen_w_reg;
    logic [ps2md_pkg::SCREEN_W-1:0]   screen_h_reg;

    logic [1:0]                       byte_count_reg, byte_count_next;
    logic [7:0]                       pkt0_reg, pkt1_reg, pkt2_reg;
    logic [CB-1:0]                    cursor_x_reg, cursor_x_next;
    logic [CB-1:0]                    cursor_y_reg, cursor_y_next;
    logic [ps2md_pkg::BTN_W-1:0]      buttons_reg, buttons_next;

    logic                             out_valid_reg, out_valid_next;
    ps2md_pkg::event_t                out_data_reg, out_data_next;
    logic                             skid_valid_reg, skid_valid_next;
    ps2md_pkg::event_t                skid_data_reg;

    logic                             accept;
    ps2md_pkg::opcode_t               opcode;
    logic [7:0]                       b;
    logic [ps2md_pkg::DIM_W-1:0]      dim_w, dim_h;
    logic                             dim_zero;
    logic [7:0]                       byte2;
    logic [2:0]                       count_inc;
    logic [2:0]                       pkt_size;
    logic                             store_byte;
    logic signed [ps2md_pkg::DELTA_W-1:0] dx, dy;
    logic signed [ps2md_pkg::WHEEL_W-1:0] wh;
    logic signed [ps2md_pkg::SUM_W-1:0]   sum_x, sum_y;
    logic                             res_valid;
    ps2md_pkg::event_t                res;

    function automatic logic [ps2md_pkg::BTN_W-1:0] BTN_W_SLICE(input logic [7:0] v);
        logic [7:0] m;
        m = v & ps2md_pkg::BUTTON_MASK;
        BTN_W_SLICE = m[ps2md_pkg::BTN_W-1:0];
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign opcode   = ps2md_pkg::opcode_t'(s_tuser);
    assign b        = s_tdata;
    assign dim_w    = ps2md_pkg::limit_dim(screen_w_reg);
    assign dim_h    = ps2md_pkg::limit_dim(screen_h_reg);
    assign dim_zero = (dim_w == '0) || (dim_h == '0);
    assign byte2    = (byte_count_reg == 2'd2) ? b : pkt2_reg;
    assign count_inc = 3'(byte_count_reg) + 3'd1;
    assign pkt_size  = four_byte_reg ? 3'd4 : 3'd3;

    assign dx = {pkt1_reg[7], pkt1_reg, 1'b0};
    assign dy = -$signed({byte2[7], byte2, 1'b0});
    assign wh = four_byte_reg ? -$signed({b[3], b[3:0]}) : '0;
    assign sum_x = $signed(ps2md_pkg::SUM_W'(cursor_x_reg)) + ps2md_pkg::SUM_W'(dx);
    assign sum_y = $signed(ps2md_pkg::SUM_W'(cursor_y_reg)) + ps2md_pkg::SUM_W'(dy);

    always_comb begin
        byte_count_next = byte_count_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        buttons_next    = buttons_reg;
        store_byte      = 1'b0;
        res_valid       = 1'b0;
        res             = '0;
        if (accept) begin
            unique case (opcode)
                ps2md_pkg::OP_RECENTER: begin
                    if (dim_zero) begin
                        cursor_x_next = '0;
                        cursor_y_next = '0;
                    end else begin
                        cursor_x_next = CB'(dim_w >> 1);
                        cursor_y_next = CB'(dim_h >> 1);
                    end
                    res_valid       = 1'b1;
                    res.pos_x       = cursor_x_next;
                    res.pos_y       = cursor_y_next;
                    res.button_bits = buttons_reg;
                end
                ps2md_pkg::OP_RESYNC: begin
                    byte_count_next = '0;
                end
                ps2md_pkg::OP_DATA: begin
                    if (enable_reg &&
                        !(byte_count_reg == 2'd0 && (b & ps2md_pkg::SYNC_MASK) == 8'd0)) begin
                        store_byte = 1'b1;
                        if (count_inc < pkt_size) begin
                            byte_count_next = count_inc[1:0];
                        end else begin
                            byte_count_next = '0;
                            if (dim_zero) begin
                                cursor_x_next = '0;
                                cursor_y_next = '0;
                            end else begin
                                cursor_x_next = ps2md_pkg::clamp_axis(sum_x, dim_w);
                                cursor_y_next = ps2md_pkg::clamp_axis(sum_y, dim_h);
                            end
                            buttons_next    = BTN_W_SLICE(pkt0_reg);
                            res_valid       = 1'b1;
                            res.pos_x       = cursor_x_next;
                            res.pos_y       = cursor_y_next;
                            res.delta_x     = dx;
                            res.delta_y     = dy;
                            res.wheel_step  = wh;
                            res.button_bits = buttons_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            four_byte_reg  <= 1'b0;
            screen_w_reg   <= ps2md_pkg::SCREEN_W'(640);
            screen_h_reg   <= ps2md_pkg::SCREEN_W'(480);
            byte_count_reg <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            buttons_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (ps2md_pkg::cfg_index_t'(cfg_index))
                    ps2md_pkg::CFG_ENABLE:    enable_reg    <= cfg_wdata[0];
                    ps2md_pkg::CFG_FOUR_BYTE: four_byte_reg <= cfg_wdata[0];
                    ps2md_pkg::CFG_SCREEN_W:  screen_w_reg  <= cfg_wdata;
                    ps2md_pkg::CFG_SCREEN_H:  screen_h_reg  <= cfg_wdata;
                endcase
            end
            byte_count_reg <= byte_count_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            buttons_reg    <= buttons_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        if (!(!out_valid_reg || m_tready) && res_valid) begin
            skid_data_reg <= res;
        end
        if (store_byte) begin
            unique case (byte_count_reg)
                2'd0: pkt0_reg <= b;
                2'd1: pkt1_reg <= b;
                2'd2: pkt2_reg <= b;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ps2md_pkg::OUT_DATA_W'(out_data_reg);

endmodule

`default_nettype wire

### sv/ps2_mouse_packet_decoder_checker.sv
// Port-level checker for ps2_mouse_packet_decoder, bound to the top level.
// Depends on ps2md_pkg and the top-level port list.
`default_nettype none

module ps2_mouse_packet_decoder_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [ps2md_pkg::OUT_DATA_W-1:0]  m_tdata
);

    logic signed [ps2md_pkg::WHEEL_W-1:0] wheel;
    assign wheel = m_tdata[48:44];

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // backpressure only with a result pending
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_dx_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[24])
        else $error("odd delta_x");

    a_wheel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> wheel >= -7)
        else $error("wheel_step out of range");

endmodule

bind ps2_mouse_packet_decoder ps2_mouse_packet_decoder_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
